[hw/rtl/hnc_pkg.sv]
// Shared constants, name table and stage types for the header name classifier.
package hnc_pkg;

  localparam int NUM_HDRS   = 22;
  localparam int NUM_CTRS   = 46;
  localparam int NAME_SLOTS = 26;
  localparam int HDR_W      = 5;
  localparam int CTR_IDX_W  = 6;
  localparam int OFFSET_W   = 13;
  localparam int READ_W     = 32;
  localparam int NAME_POS_W = 5;

  localparam int DEF_MAX_LINE_BYTES = 4096;
  localparam int DEF_COUNTER_BITS   = 32;

  // Counter map: known counts, then duplicate counts, then the two unknown classes
  localparam logic [CTR_IDX_W-1:0] CTR_DUP_BASE = CTR_IDX_W'(NUM_HDRS);
  localparam logic [CTR_IDX_W-1:0] CTR_EXT      = CTR_IDX_W'(44);
  localparam logic [CTR_IDX_W-1:0] CTR_OTHER    = CTR_IDX_W'(45);

  typedef enum logic [1:0] {
    REQ_BYTE         = 2'd0,
    REQ_CLR_PRESENT  = 2'd1,
    REQ_CLR_COUNTERS = 2'd2,
    REQ_READ_CTR     = 2'd3
  } req_t;

  localparam logic [1:0] CLS_KNOWN   = 2'd0;
  localparam logic [1:0] CLS_EXT     = 2'd1;
  localparam logic [1:0] CLS_OTHER   = 2'd2;
  localparam logic [1:0] CLS_INVALID = 2'd3;

  // Known names, right-justified: the colon sits in the low byte
  localparam logic [NAME_SLOTS*8-1:0] NAME_TAB [NUM_HDRS] = '{
    "allow:", "host:", "encapsulated:", "user-agent:", "x-client-ip:",
    "x-server-ip:", "x-proxy-addr:", "x-proxy-port:",
    "x-encapsulated-protocol:", "x-scan-progress-interval:",
    "x-chunk-extensions:", "preview:", "date:", "expires:", "pragma:",
    "trailer:", "upgrade:", "authorization:", "from:", "connection:",
    "cache-control:", "referer:"
  };

  localparam int NAME_LEN [NUM_HDRS] = '{
    6, 5, 13, 11, 12, 12, 13, 13, 24, 25, 19, 8, 5, 8, 7, 8, 8, 14, 5, 11, 14, 8
  };

  // Byte of name k at position pos, zero past the end of the name
  function automatic logic [7:0] name_char(input int k, input logic [NAME_POS_W-1:0] pos);
    logic [7:0] ch;
    int         len;
    ch  = 8'h00;
    len = NAME_LEN[k];
    if (int'(pos) < len) begin
      ch = NAME_TAB[k][(len - 1 - int'(pos)) * 8 +: 8];
    end
    return ch;
  endfunction

  typedef struct packed {
    logic                 emit;
    logic [1:0]           cls;
    logic [HDR_W-1:0]     hdr;
    logic                 dup;
    logic [OFFSET_W-1:0]  voff;
    logic                 bump;
    logic [CTR_IDX_W-1:0] bump_idx;
  } line_res_t;

  typedef struct packed {
    logic                 bump;
    logic                 read;
    logic                 clear;
    logic                 oor;
    logic [CTR_IDX_W-1:0] addr;
  } ctr_op_t;

endpackage

[hw/rtl/hnc_line_parser.sv]
// Per-byte line state, candidate matching, presence bits and line classification.
module hnc_line_parser import hnc_pkg::*; #(
  parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       item_ok,
  input  req_t       req,
  input  logic [7:0] char_byte,
  input  logic       end_of_line,
  output line_res_t  res
);

  localparam int LPW = $clog2(MAX_LINE_BYTES + 1);
  localparam int VW  = (LPW > OFFSET_W) ? LPW : OFFSET_W;
  localparam logic [LPW-1:0] POS_MAX = LPW'(MAX_LINE_BYTES);

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_NAME  = 4'b0010,
    PH_GAP   = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_t;

  localparam logic [1:0] EXT_NONE  = 2'd0;
  localparam logic [1:0] EXT_X     = 2'd1;
  localparam logic [1:0] EXT_XDASH = 2'd2;
  localparam logic [1:0] EXT_FAIL  = 2'd3;

  logic [NUM_HDRS-1:0]   cand_alive, cand_alive_next;
  logic [LPW-1:0]        line_pos, line_pos_next;
  logic [NAME_POS_W-1:0] name_pos, name_pos_next;
  phase_t                phase, phase_next;
  logic [HDR_W-1:0]      matched, matched_next;
  logic [LPW-1:0]        value_start, value_start_next;
  logic                  invalid_seen, invalid_seen_next;
  logic [1:0]            ext_state, ext_state_next;
  logic [NUM_HDRS-1:0]   present, present_next;

  logic [7:0]          lc;
  logic                ws, inv_b, is_byte, in_name, hit;
  logic [HDR_W-1:0]    hit_idx;
  logic [NUM_HDRS-1:0] alive_step;
  logic [1:0]          ext_step;
  logic [7:0]          ch_tab [NUM_HDRS];
  logic [LPW-1:0]      voff_src;
  logic [VW-1:0]       voff_wide;
  logic                dup;

  // Classify the byte
  always_comb begin
    lc      = (char_byte >= 8'h41 && char_byte <= 8'h5A) ? char_byte + 8'h20 : char_byte;
    ws      = (char_byte >= 8'h09 && char_byte <= 8'h0D) || char_byte == 8'h20;
    inv_b   = char_byte[7] || (!(char_byte >= 8'h20 && char_byte <= 8'h7E) && !ws);
    is_byte = item_ok && req == REQ_BYTE;
    in_name = (phase == PH_LEAD && !ws) || phase == PH_NAME;
  end

  // Step all candidates against the byte at the current name position
  always_comb begin
    alive_step = '0;
    hit        = 1'b0;
    hit_idx    = matched;
    for (int k = 0; k < NUM_HDRS; k++) begin
      ch_tab[k] = name_char(k, name_pos);
      if (cand_alive[k] && ch_tab[k] != 8'h00 && ch_tab[k] == lc) begin
        if (ch_tab[k] == 8'h3A) begin
          hit     = 1'b1;
          hit_idx = HDR_W'(k);
        end else begin
          alive_step[k] = 1'b1;
        end
      end
    end
    if (name_pos == '0) begin
      ext_step = (lc == 8'h78) ? EXT_X : EXT_FAIL;
    end else if (name_pos == NAME_POS_W'(1) && ext_state == EXT_X) begin
      ext_step = (lc == 8'h2D) ? EXT_XDASH : EXT_FAIL;
    end else begin
      ext_step = ext_state;
    end
  end

  // Advance the line state and build the line result
  always_comb begin
    cand_alive_next   = cand_alive;
    line_pos_next     = line_pos;
    name_pos_next     = name_pos;
    phase_next        = phase;
    matched_next      = matched;
    value_start_next  = value_start;
    invalid_seen_next = invalid_seen;
    ext_state_next    = ext_state;
    present_next      = present;
    res               = '0;
    voff_src          = '0;
    voff_wide         = '0;
    dup               = 1'b0;

    if (is_byte) begin
      invalid_seen_next = invalid_seen | inv_b;
      if (in_name) begin
        cand_alive_next = alive_step;
        ext_state_next  = ext_step;
        name_pos_next   = (name_pos != '1) ? name_pos + 1'b1 : name_pos;
        if (hit) begin
          matched_next = hit_idx;
          phase_next   = PH_GAP;
        end else begin
          phase_next = PH_NAME;
        end
      end else if (phase == PH_GAP && !ws) begin
        phase_next       = PH_VALUE;
        value_start_next = line_pos;
      end
      if (line_pos < POS_MAX) begin
        line_pos_next = line_pos + 1'b1;
      end

      if (end_of_line) begin
        res.emit = 1'b1;
        if (phase_next == PH_GAP || phase_next == PH_VALUE) begin
          dup       = present[matched_next];
          voff_src  = (phase_next == PH_VALUE) ? value_start_next : line_pos_next;
          voff_wide = VW'(voff_src);
          res.cls   = CLS_KNOWN;
          res.hdr   = matched_next;
          res.dup   = dup;
          res.voff  = voff_wide[OFFSET_W-1:0];
          res.bump  = 1'b1;
          res.bump_idx = dup ? CTR_DUP_BASE + CTR_IDX_W'(matched_next)
                             : CTR_IDX_W'(matched_next);
          present_next[matched_next] = 1'b1;
        end else if (invalid_seen_next) begin
          res.cls = CLS_INVALID;
        end else if (ext_state_next == EXT_XDASH) begin
          res.cls      = CLS_EXT;
          res.bump     = 1'b1;
          res.bump_idx = CTR_EXT;
        end else begin
          res.cls      = CLS_OTHER;
          res.bump     = 1'b1;
          res.bump_idx = CTR_OTHER;
        end
        // Drop the finished line
        cand_alive_next   = '1;
        line_pos_next     = '0;
        name_pos_next     = '0;
        phase_next        = PH_LEAD;
        matched_next      = '0;
        value_start_next  = '0;
        invalid_seen_next = 1'b0;
        ext_state_next    = EXT_NONE;
      end
    end

    if (item_ok && req == REQ_CLR_PRESENT) begin
      present_next = '0;
    end
  end

  // Hold or advance the line state
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_alive   <= '1;
      line_pos     <= '0;
      name_pos     <= '0;
      phase        <= PH_LEAD;
      matched      <= '0;
      value_start  <= '0;
      invalid_seen <= 1'b0;
      ext_state    <= EXT_NONE;
      present      <= '0;
    end else if (adv) begin
      cand_alive   <= cand_alive_next;
      line_pos     <= line_pos_next;
      name_pos     <= name_pos_next;
      phase        <= phase_next;
      matched      <= matched_next;
      value_start  <= value_start_next;
      invalid_seen <= invalid_seen_next;
      ext_state    <= ext_state_next;
      present      <= present_next;
    end
  end

  a_eol_restarts_line: assert property (@(posedge clk) disable iff (rst)
    (adv && is_byte && end_of_line)
      |=> (phase == PH_LEAD && line_pos == '0 && cand_alive == '1 && !invalid_seen))
    else $error("line state not restarted after end of line");

  a_known_marks_present: assert property (@(posedge clk) disable iff (rst)
    (adv && res.emit && res.cls == CLS_KNOWN) |=> present[$past(res.hdr)])
    else $error("reported header not marked present");

endmodule

[hw/rtl/hnc_counter_bank.sv]
// Statistics counter memory with valid bits, saturating increment and read-back.
module hnc_counter_bank import hnc_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  ctr_op_t           op,
  output logic [READ_W-1:0] read_value
);

  localparam int RW = (COUNTER_BITS > READ_W) ? COUNTER_BITS : READ_W;

  ctr_op_t                 s2;
  logic [COUNTER_BITS-1:0] mem [NUM_CTRS];
  logic [COUNTER_BITS-1:0] rd_data, fwd_val, cur, inc_val;
  logic                    fwd_hit;
  logic [NUM_CTRS-1:0]     ctr_valid;
  logic [RW-1:0]           read_wide;

  // Hold the operation for the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2      <= '0;
      fwd_hit <= 1'b0;
    end else if (adv) begin
      s2      <= op;
      fwd_hit <= s2.bump && s2.addr == op.addr;
    end
  end

  // Read the next entry, write back the updated one
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= mem[op.addr];
      fwd_val <= inc_val;
      if (s2.bump) begin
        mem[s2.addr] <= inc_val;
      end
    end
  end

  // Valid bits: an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_valid <= '0;
    end else if (adv) begin
      if (s2.clear) begin
        ctr_valid <= '0;
      end else if (s2.bump) begin
        ctr_valid[s2.addr] <= 1'b1;
      end
    end
  end

  // Pick the current count, bypassing a write made on the previous edge
  always_comb begin
    if (!ctr_valid[s2.addr]) begin
      cur = '0;
    end else if (fwd_hit) begin
      cur = fwd_val;
    end else begin
      cur = rd_data;
    end
    inc_val    = (&cur) ? cur : cur + 1'b1;
    read_wide  = RW'(cur);
    read_value = (s2.read && !s2.oor) ? read_wide[READ_W-1:0] : '0;
  end

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s2.bump, s2.read, s2.clear}))
    else $error("more than one counter operation in the update stage");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (adv && s2.clear) |=> ctr_valid == '0)
    else $error("counters not cleared");

  a_bump_validates: assert property (@(posedge clk) disable iff (rst)
    (adv && s2.bump) |=> ctr_valid[$past(s2.addr)])
    else $error("bumped counter not marked valid");

endmodule

[hw/rtl/header_name_classifier.sv]
// Top level: input register, line parser, counter bank and result register.
// Result path: an item passes the input register, the counter stage register and the
//   result register before its result is valid.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous; clears line state, presence bits and counter valid bits at once,
//   so no clearing pass follows and items are accepted in the next cycle.
module header_name_classifier import hnc_pkg::*; #(
  parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
  parameter int COUNTER_BITS   = DEF_COUNTER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           req_type,
  input  logic [7:0]           char_byte,
  input  logic                 end_of_line,
  input  logic [CTR_IDX_W-1:0] counter_index,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 result_kind,
  output logic [1:0]           line_class,
  output logic [HDR_W-1:0]     header_index,
  output logic                 was_duplicate,
  output logic [OFFSET_W-1:0]  value_offset,
  output logic [READ_W-1:0]    counter_value
);

  logic adv;

  logic                 s1_valid;
  req_t                 s1_req;
  logic [7:0]           s1_byte;
  logic                 s1_eol;
  logic [CTR_IDX_W-1:0] s1_idx;

  line_res_t         line_res;
  ctr_op_t           ctr_op;
  logic [READ_W-1:0] ctr_read;

  logic                s2_valid;
  logic                s2_kind;
  logic [1:0]          s2_cls;
  logic [HDR_W-1:0]    s2_hdr;
  logic                s2_dup;
  logic [OFFSET_W-1:0] s2_voff;

  // Advance unless a finished result is waiting on a stalled receiver
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req  <= req_t'(req_type);
      s1_byte <= char_byte;
      s1_eol  <= end_of_line;
      s1_idx  <= counter_index;
    end
  end

  hnc_line_parser #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_ok    (s1_valid),
    .req        (s1_req),
    .char_byte  (s1_byte),
    .end_of_line(s1_eol),
    .res        (line_res)
  );

  // Build the counter operation for this item
  always_comb begin
    ctr_op       = '0;
    ctr_op.bump  = line_res.bump;
    ctr_op.read  = s1_valid && s1_req == REQ_READ_CTR;
    ctr_op.clear = s1_valid && s1_req == REQ_CLR_COUNTERS;
    ctr_op.oor   = s1_idx >= CTR_IDX_W'(NUM_CTRS);
    if (line_res.bump) begin
      ctr_op.addr = line_res.bump_idx;
    end else if (!ctr_op.oor) begin
      ctr_op.addr = s1_idx;
    end
  end

  hnc_counter_bank #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_counters (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .op        (ctr_op),
    .read_value(ctr_read)
  );

  // Counter stage register for the line result
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= line_res.emit || ctr_op.read;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind <= ctr_op.read;
      s2_cls  <= line_res.cls;
      s2_hdr  <= line_res.hdr;
      s2_dup  <= line_res.dup;
      s2_voff <= line_res.voff;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_kind   <= s2_kind;
      line_class    <= s2_cls;
      header_index  <= s2_hdr;
      was_duplicate <= s2_dup;
      value_offset  <= s2_voff;
      counter_value <= ctr_read;
    end
  end

endmodule
